// ----- sv/sle_pkg.sv -----
`timescale 1ns / 1ps

package sle_pkg;

  // Width of the line_capacity register, fixed by the register map.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_MIN = 5'd2;

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;

  // Register indexes on the configuration port.
  localparam logic CFG_ECHO = 1'b0;
  localparam logic CFG_CAP  = 1'b1;

  // Terminal bytes.
  localparam logic [7:0] CH_CTRL_C  = 8'h03;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  // CSI parameter values and saturation limit.
  localparam logic [6:0] CSI_HOME   = 7'd1;
  localparam logic [6:0] CSI_DELETE = 7'd3;
  localparam logic [6:0] CSI_END    = 7'd4;
  localparam logic [6:0] CSI_MAX    = 7'd99;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_DISCARD,
    OP_LINE_END,
    OP_BACKSPACE,
    OP_INSERT,
    OP_RIGHT,
    OP_LEFT,
    OP_HOME,
    OP_DELETE,
    OP_END
  } sle_op_t;

  typedef struct packed {
    sle_op_t    op;
    logic [7:0] ch;
  } sle_cmd_t;

  typedef struct packed {
    logic             echo_en;
    logic [CAP_W-1:0] cap;      // already clamped to the usable range
  } sle_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE,
    BK_TAIL,
    BK_PAD,
    BK_BS,
    BK_NONE
  } sle_bk_state_t;

endpackage

// ----- sv/sle_front.sv -----
`timescale 1ns / 1ps

module sle_front import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       q_full,
  output logic       push,
  output sle_cmd_t   push_cmd
);

  logic       esc_r, esc_nxt;
  logic       csi_r, csi_nxt;
  logic [6:0] num_r, num_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       pair_r, pair_nxt;
  logic [9:0] num_x;
  logic [7:0] ch;
  sle_op_t    op;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign num_x     = {num_r, 3'b000} + {2'b00, num_r, 1'b0} + {6'b000000, ch[3:0]};

  // Classify the word; escape and pair tracking depend only on the byte stream.
  always_comb begin
    esc_nxt  = esc_r;
    csi_nxt  = csi_r;
    num_nxt  = num_r;
    prev_nxt = prev_r;
    pair_nxt = pair_r;
    op       = OP_NOP;
    if (in_tuser) begin
      op = OP_CLEAR;
    end else begin
      prev_nxt = ch;
      if (!esc_r) begin
        if (ch < CH_SPACE || ch == CH_DEL) begin
          if (ch == CH_CTRL_C) begin
            op = OP_DISCARD;
          end else if (ch == CH_CR || ch == CH_LF) begin
            if (pair_r || (ch == CH_LF && prev_r != CH_CR) ||
                (ch == CH_CR && prev_r != CH_LF)) begin
              op       = OP_LINE_END;
              pair_nxt = 1'b0;
            end else begin
              pair_nxt = 1'b1;
            end
          end else if (ch == CH_DEL || ch == CH_BS) begin
            op = OP_BACKSPACE;
          end else if (ch == CH_ESC) begin
            esc_nxt = 1'b1;
          end
        end else begin
          op = OP_INSERT;
        end
      end else if (!csi_r) begin
        if (ch == CH_LBRACK) begin
          csi_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          num_nxt = 7'd0;
        end
      end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
        num_nxt = (num_x > 10'(CSI_MAX)) ? CSI_MAX : num_x[6:0];
      end else begin
        if (ch == CH_UPPER_C) begin
          op = OP_RIGHT;
        end else if (ch == CH_UPPER_D) begin
          op = OP_LEFT;
        end else if (ch == CH_TILDE) begin
          if (num_r == CSI_HOME) begin
            op = OP_HOME;
          end else if (num_r == CSI_DELETE) begin
            op = OP_DELETE;
          end else if (num_r == CSI_END) begin
            op = OP_END;
          end
        end
        esc_nxt = 1'b0;
        csi_nxt = 1'b0;
        num_nxt = 7'd0;
      end
    end
  end

  assign push_cmd.op = op;
  assign push_cmd.ch = ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      csi_r  <= 1'b0;
      num_r  <= 7'd0;
      prev_r <= 8'h00;
      pair_r <= 1'b0;
    end else if (push) begin
      esc_r  <= esc_nxt;
      csi_r  <= csi_nxt;
      num_r  <= num_nxt;
      prev_r <= prev_nxt;
      pair_r <= pair_nxt;
    end
  end

  a_csi_needs_esc: assert property (@(posedge clk) disable iff (!rst_n)
    csi_r |-> esc_r)
    else $error("CSI state set outside an escape");

  a_num_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    num_r <= CSI_MAX)
    else $error("CSI number above saturation limit");

  a_num_only_in_csi: assert property (@(posedge clk) disable iff (!rst_n)
    !csi_r |-> num_r == 7'd0)
    else $error("CSI number left over outside a sequence");

endmodule

// ----- sv/sle_queue.sv -----
`timescale 1ns / 1ps

module sle_queue import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sle_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output sle_cmd_t pop_cmd,
  output logic     nonempty
);

  sle_cmd_t        ent_r [Q_DEPTH];
  logic [Q_PW-1:0] wp_r, wp_nxt;
  logic [Q_PW-1:0] rp_r, rp_nxt;
  logic [Q_PW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (Q_PW+1)'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_cmd  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_PW+1)'(push) - (Q_PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PW+1)'(Q_DEPTH))
    else $error("queue fill count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ----- sv/sle_back.sv -----
`timescale 1ns / 1ps

module sle_back import sle_pkg::*; #(
  parameter int LINE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sle_cfg_t    cfg,
  input  logic        q_valid,
  input  sle_cmd_t    q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int RW = $clog2(2 * LINE_DEPTH + 2);

  typedef logic [LINE_DEPTH-1:0][7:0] store_t;

  sle_bk_state_t state_r, state_nxt;

  store_t        store_r, store_nxt, st_dn, st_up;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] length_r, length_nxt;
  logic          flag_r, flag_nxt;

  logic          pre_r, pre_nxt;
  logic [7:0]    pre_byte_r, pre_byte_nxt;
  logic [CW-1:0] tidx_r, tidx_nxt;
  logic [CW-1:0] tend_r, tend_nxt;
  logic          pad_r, pad_nxt;
  logic [CW-1:0] bs_r, bs_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          done_r, done_nxt;

  logic          ov_r;
  logic          o_ev_r, o_last_r, o_done_r, o_flag_r;
  logic [7:0]    o_byte_r;
  logic [3:0]    o_len_r;

  logic          slot_free, ld;
  logic [CW-1:0] cap_c, cap_m1, lc, cc, amt;
  logic          sh_right, sh_left;
  logic [CW-1:0] sl_lo, sl_hi;
  logic          w_ev, w_last;
  logic [7:0]    w_byte;

  function automatic sle_bk_state_t sel_phase(input logic pre_p, input logic tail_p,
                                              input logic pad_p, input logic bs_p);
    if (pre_p) return BK_PRE;
    else if (tail_p) return BK_TAIL;
    else if (pad_p) return BK_PAD;
    else if (bs_p) return BK_BS;
    else return BK_IDLE;
  endfunction

  assign st_dn = {store_r[LINE_DEPTH-2:0], 8'h00};
  assign st_up = {8'h00, store_r[LINE_DEPTH-1:1]};

  assign slot_free = !ov_r || out_tready;
  assign q_pop     = (state_r == BK_IDLE) && q_valid;
  assign ld        = (state_r != BK_IDLE) && slot_free;

  // Clamp the stored length and cursor to the current capacity.
  assign cap_c  = CW'(cfg.cap);
  assign cap_m1 = cap_c - 1'b1;
  assign lc     = (length_r > cap_m1) ? cap_m1 : length_r;
  assign cc     = (cursor_r > lc) ? lc : cursor_r;
  assign amt    = lc - cc;

  // Edit the line on pop and plan the echo; advance the plan on each word.
  always_comb begin
    store_nxt    = store_r;
    cursor_nxt   = cursor_r;
    length_nxt   = length_r;
    flag_nxt     = flag_r;
    pre_nxt      = pre_r;
    pre_byte_nxt = pre_byte_r;
    tidx_nxt     = tidx_r;
    tend_nxt     = tend_r;
    pad_nxt      = pad_r;
    bs_nxt       = bs_r;
    rem_nxt      = rem_r;
    done_nxt     = done_r;
    sh_right     = 1'b0;
    sh_left      = 1'b0;
    sl_lo        = cc;
    sl_hi        = cc;
    if (q_pop) begin
      cursor_nxt   = cc;
      length_nxt   = lc;
      pre_nxt      = 1'b0;
      pre_byte_nxt = q_cmd.ch;
      tidx_nxt     = cc;
      tend_nxt     = cc;
      pad_nxt      = 1'b0;
      bs_nxt       = '0;
      done_nxt     = 1'b0;
      unique case (q_cmd.op)
        OP_NOP: begin
        end
        OP_CLEAR: begin
          cursor_nxt = '0;
          length_nxt = '0;
          flag_nxt   = 1'b0;
        end
        OP_DISCARD: begin
          cursor_nxt   = '0;
          length_nxt   = '0;
          flag_nxt     = 1'b0;
          store_nxt[0] = 8'h00;
          pre_nxt      = 1'b1;
          pre_byte_nxt = CH_LF;
          done_nxt     = 1'b1;
        end
        OP_LINE_END: begin
          flag_nxt     = (lc != '0);
          cursor_nxt   = '0;
          pre_nxt      = 1'b1;
          pre_byte_nxt = CH_LF;
          done_nxt     = 1'b1;
        end
        OP_BACKSPACE: begin
          if (cc != '0) begin
            sh_left      = 1'b1;
            sl_lo        = cc - 1'b1;
            sl_hi        = lc - 1'b1;
            cursor_nxt   = cc - 1'b1;
            length_nxt   = lc - 1'b1;
            pre_nxt      = 1'b1;
            pre_byte_nxt = CH_BS;
            tidx_nxt     = cc - 1'b1;
            tend_nxt     = lc - 1'b1;
            pad_nxt      = 1'b1;
            bs_nxt       = amt + 1'b1;
          end
        end
        OP_INSERT: begin
          if ((lc + 1'b1) < cap_c) begin
            sh_right   = 1'b1;
            cursor_nxt = cc + 1'b1;
            length_nxt = lc + 1'b1;
            pre_nxt    = 1'b1;
            tidx_nxt   = cc + 1'b1;
            tend_nxt   = lc + 1'b1;
            bs_nxt     = amt;
          end
        end
        OP_DELETE: begin
          if (cc < lc) begin
            sh_left    = 1'b1;
            sl_lo      = cc;
            sl_hi      = lc - 1'b1;
            length_nxt = lc - 1'b1;
            tend_nxt   = lc - 1'b1;
            pad_nxt    = 1'b1;
            bs_nxt     = amt;
          end
        end
        OP_RIGHT: begin
          if (cc < lc) begin
            tend_nxt   = cc + 1'b1;
            cursor_nxt = cc + 1'b1;
          end
        end
        OP_LEFT: begin
          if (cc != '0) begin
            cursor_nxt = cc - 1'b1;
            bs_nxt     = CW'(1);
          end
        end
        OP_HOME: begin
          bs_nxt     = cc;
          cursor_nxt = '0;
        end
        OP_END: begin
          tend_nxt   = lc;
          cursor_nxt = lc;
        end
        default: begin
        end
      endcase
      for (int j = 0; j < LINE_DEPTH; j++) begin
        if (sh_right) begin
          if (CW'(j) == cc) begin
            store_nxt[j] = q_cmd.ch;
          end else if (CW'(j) > cc && CW'(j) <= lc) begin
            store_nxt[j] = st_dn[j];
          end
        end
        if (sh_left && CW'(j) >= sl_lo && CW'(j) < sl_hi) begin
          store_nxt[j] = st_up[j];
        end
      end
      rem_nxt = RW'(pre_nxt) + RW'(tend_nxt - tidx_nxt) + RW'(pad_nxt) + RW'(bs_nxt);
    end else if (ld) begin
      unique case (state_r)
        BK_PRE:  pre_nxt  = 1'b0;
        BK_TAIL: tidx_nxt = tidx_r + 1'b1;
        BK_PAD:  pad_nxt  = 1'b0;
        BK_BS:   bs_nxt   = bs_r - 1'b1;
        default: begin
        end
      endcase
      rem_nxt = (state_r == BK_NONE) ? '0 : rem_r - 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (!cfg.echo_en || rem_nxt == '0) begin
            state_nxt = BK_NONE;
          end else begin
            state_nxt = sel_phase(pre_nxt, tidx_nxt != tend_nxt, pad_nxt, bs_nxt != '0);
          end
        end
      end
      BK_NONE: begin
        if (slot_free) state_nxt = BK_IDLE;
      end
      default: begin
        if (slot_free) begin
          state_nxt = sel_phase(pre_nxt, tidx_nxt != tend_nxt, pad_nxt, bs_nxt != '0);
        end
      end
    endcase
  end

  // Word content for the current phase.
  always_comb begin
    unique case (state_r)
      BK_PRE:  w_byte = pre_byte_r;
      BK_TAIL: w_byte = store_r[tidx_r[IW-1:0]];
      BK_PAD:  w_byte = CH_SPACE;
      BK_BS:   w_byte = CH_BS;
      default: w_byte = 8'h00;
    endcase
    w_ev   = (state_r != BK_NONE);
    w_last = (state_r == BK_NONE) || (rem_r == RW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      cursor_r <= '0;
      length_r <= '0;
      flag_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
      flag_r   <= flag_nxt;
      if (ld) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    store_r    <= store_nxt;
    pre_r      <= pre_nxt;
    pre_byte_r <= pre_byte_nxt;
    tidx_r     <= tidx_nxt;
    tend_r     <= tend_nxt;
    pad_r      <= pad_nxt;
    bs_r       <= bs_nxt;
    rem_r      <= rem_nxt;
    done_r     <= done_nxt;
    if (ld) begin
      o_ev_r   <= w_ev;
      o_byte_r <= w_byte;
      o_last_r <= w_last;
      o_done_r <= w_last && done_r;
      o_flag_r <= flag_r;
      o_len_r  <= 4'(length_r);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, o_len_r, o_flag_r, o_done_r, o_byte_r};
  assign out_tuser  = o_ev_r;
  assign out_tlast  = o_last_r;

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= length_r)
    else $error("cursor beyond line length");

  a_silent_word: assert property (@(posedge clk) disable iff (!rst_n)
    ld && state_r == BK_NONE |=> out_tlast && !out_tuser)
    else $error("silent result not marked last");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    ld && state_r != BK_NONE && rem_r == RW'(1) |=> state_r == BK_IDLE && out_tlast)
    else $error("final echo word did not end the run");

  a_run_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    ld && state_r != BK_NONE && rem_r != RW'(1) |=> !out_tlast && state_r != BK_IDLE)
    else $error("echo run cut short");

endmodule

// ----- sv/serial_line_editor_unit.sv -----
`timescale 1ns / 1ps

// Line editor for bytes received from a terminal.
// in_*  : one word per received byte (in_tuser = 0) or per "line taken" command
//         (in_tuser = 1, empties the line). A two-entry queue sits behind the
//         decoder, so in_tready stays high until that queue is full.
// out_* : the echo run of each input word, one echo byte per word, tlast on the
//         final word. A word with no echo (tuser = 0) stands alone as the run.
//         tdata also carries line_end (on the last word), has_data and the
//         line length after the edit.
// cfg_* : write channel, always ready; index 0 echo_enable, 1 line_capacity.
//         Write only while the block is idle.
// Flow: an accepted input word is written into the queue; the edit engine pops
// it only while idle, applies the edit and then loads the echo words of the run
// one after another into the output register, so it takes no new word until
// the last word of the run is loaded.
// Reset: cursor, length and flags clear, echo on, capacity 16; the line store
// holds no defined data until written and needs no clearing pass.
// A stalled receiver holds the output word; the engine then waits, the queue
// fills and in_tready drops.
module serial_line_editor_unit import sle_pkg::*; #(
  parameter int LINE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [7:0] echo_byte, [8] line_end,
                                       // [9] has_data, [13:10] line_length
  output logic             out_tuser,  // [0] echo_valid
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CAP_W-1:0] cfg_data
);

  logic             echo_r;
  logic [CAP_W-1:0] cap_r;
  sle_cfg_t         cfg;

  logic     push, q_full, q_pop, q_nonempty;
  sle_cmd_t push_cmd, pop_cmd;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
      cap_r  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ECHO: echo_r <= cfg_data[0];
        CFG_CAP:  cap_r  <= cfg_data;
      endcase
    end
  end

  // Hold the capacity within two and the store depth.
  assign cfg.echo_en = echo_r;
  assign cfg.cap = (cap_r < CAP_MIN) ? CAP_MIN :
                   (cap_r > CAP_W'(LINE_DEPTH)) ? CAP_W'(LINE_DEPTH) : cap_r;

  // Front: decode escapes and line ends, classify each word.
  sle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple decode from the edit engine.
  sle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .nonempty (q_nonempty)
  );

  // Back: apply edits to the line store and stream the echo.
  sle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_nonempty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
